// ===== hdl/hse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_pkg
// shared widths, defaults, controller states, datapath opcodes and status
// ----------------------------------------------------------------------------
package hse_pkg;

    localparam int KEY_W     = 32;
    localparam int DEPTH_DEF = 64;

    typedef enum logic [3:0] {
        S_LOAD,
        S_BUILD_INIT,
        S_BUILD_CHK,
        S_ROOT_LD,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_EXT_INIT,
        S_EXT_CHK,
        S_EXT_SWAP,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_STORE,
        OP_BUILD_INIT,
        OP_ROOT_RD,
        OP_VAL_ROOT,
        OP_SIFT_RD,
        OP_SIFT_STEP,
        OP_EXT_INIT,
        OP_EXT_RD,
        OP_EXT_SWAP,
        OP_EMIT_INIT,
        OP_EMIT_RD,
        OP_EMIT_LD,
        OP_EMIT_DONE
    } t_op;

    typedef struct packed {
        logic idx_zero;
        logic idx_lt2;
        logic sift_stop;
        logic out_final;
    } t_stat;

endpackage

// ===== hdl/hse_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_if
// valid/ready channels for input keys and sorted results
// ----------------------------------------------------------------------------
interface hse_in_if import hse_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] key;
    logic                    last;

    modport source (output valid, output key, output last, input ready);
    modport sink   (input valid, input key, input last, output ready);
endinterface

interface hse_out_if import hse_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] sorted_key;
    logic                    final_res;
    logic                    dropped;

    modport source (output valid, output sorted_key, output final_res, output dropped,
                    input ready);
    modport sink   (input valid, input sorted_key, input final_res, input dropped,
                    output ready);
endinterface

// ===== hdl/hse_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_ctrl
// sequencer for load, heap build, extraction and emit phases
// ----------------------------------------------------------------------------
module hse_ctrl import hse_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_last,
    input  logic  i_out_fire,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_op   o_op
);

    t_state r_state, n_state;
    logic   r_extract, n_extract;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_extract <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_extract <= n_extract;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_extract  = r_extract;
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op = OP_STORE;
                    if (i_in_last) begin
                        n_state = S_BUILD_INIT;
                    end
                end
            end
            S_BUILD_INIT: begin
                o_op      = OP_BUILD_INIT;
                n_extract = 1'b0;
                n_state   = S_BUILD_CHK;
            end
            S_BUILD_CHK: begin
                if (i_stat.idx_zero) begin
                    n_state = S_EXT_INIT;
                end else begin
                    o_op    = OP_ROOT_RD;
                    n_state = S_ROOT_LD;
                end
            end
            S_ROOT_LD: begin
                o_op    = OP_VAL_ROOT;
                n_state = S_SIFT_RD;
            end
            S_SIFT_RD: begin
                o_op    = OP_SIFT_RD;
                n_state = S_SIFT_CMP;
            end
            S_SIFT_CMP: begin
                o_op = OP_SIFT_STEP;
                if (!i_stat.sift_stop) begin
                    n_state = S_SIFT_RD;
                end else if (r_extract) begin
                    n_state = S_EXT_CHK;
                end else begin
                    n_state = S_BUILD_CHK;
                end
            end
            S_EXT_INIT: begin
                o_op      = OP_EXT_INIT;
                n_extract = 1'b1;
                n_state   = S_EXT_CHK;
            end
            S_EXT_CHK: begin
                if (i_stat.idx_lt2) begin
                    o_op      = OP_EMIT_INIT;
                    n_extract = 1'b0;
                    n_state   = S_EMIT_RD;
                end else begin
                    o_op    = OP_EXT_RD;
                    n_state = S_EXT_SWAP;
                end
            end
            S_EXT_SWAP: begin
                o_op    = OP_EXT_SWAP;
                n_state = S_SIFT_RD;
            end
            S_EMIT_RD: begin
                o_op    = OP_EMIT_RD;
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                o_op    = OP_EMIT_LD;
                n_state = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (i_out_fire) begin
                    if (i_stat.out_final) begin
                        o_op    = OP_EMIT_DONE;
                        n_state = S_LOAD;
                    end else begin
                        o_op    = OP_EMIT_RD;
                        n_state = S_EMIT_LD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

// ===== hdl/hse_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_dp
// key store with two read ports, sift-down compare, counters and result register
// ----------------------------------------------------------------------------
module hse_dp import hse_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_op                     i_op,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic                    i_out_fire,
    output t_stat                   o_stat,
    output logic                    o_out_valid,
    output logic signed [KEY_W-1:0] o_out_key,
    output logic                    o_out_final,
    output logic                    o_out_drop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [KEY_W-1:0] r_mem [DEPTH];
    logic signed [KEY_W-1:0] r_rda, r_rdb;
    logic signed [KEY_W-1:0] r_val;
    logic [CW-1:0]           r_count;
    logic                    r_ovf;
    logic [CW-1:0]           r_idx;
    logic [CW-1:0]           r_size;
    logic [AW-1:0]           r_hole;
    logic                    r_out_valid;
    logic signed [KEY_W-1:0] r_out_key;
    logic                    r_out_final;
    logic                    r_out_drop;

    logic [AW-1:0]           w_addr_a, w_addr_b;
    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic signed [KEY_W-1:0] w_wdata;
    logic [CW-1:0]           w_idx_m1;
    logic [CW:0]             w_left, w_right;
    logic                    w_has_l, w_has_r;
    logic                    w_sel_l, w_sel_r, w_move;
    logic                    w_room;

    assign w_idx_m1 = r_idx - CW'(1);
    assign w_left   = {CW'(r_hole), 1'b1};
    assign w_right  = w_left + (CW + 1)'(1);
    assign w_has_l  = w_left < {1'b0, r_size};
    assign w_has_r  = w_right < {1'b0, r_size};
    assign w_sel_l  = w_has_l && (r_rda > r_val);
    assign w_sel_r  = w_has_r && (w_sel_l ? (r_rdb > r_rda) : (r_rdb > r_val));
    assign w_move   = w_sel_l || w_sel_r;
    assign w_room   = r_count < CW'(DEPTH);

    // read and write port steering
    always_comb begin
        w_addr_a = '0;
        w_addr_b = '0;
        w_we     = 1'b0;
        w_waddr  = r_hole;
        w_wdata  = r_val;
        case (i_op)
            OP_STORE: begin
                w_we    = w_room;
                w_waddr = r_count[AW-1:0];
                w_wdata = i_key;
            end
            OP_ROOT_RD: begin
                w_addr_a = w_idx_m1[AW-1:0];
            end
            OP_SIFT_RD: begin
                w_addr_a = w_left[AW-1:0];
                w_addr_b = w_right[AW-1:0];
            end
            OP_SIFT_STEP: begin
                w_we    = 1'b1;
                w_waddr = r_hole;
                if (w_sel_r) begin
                    w_wdata = r_rdb;
                end else if (w_sel_l) begin
                    w_wdata = r_rda;
                end
            end
            OP_EXT_RD: begin
                w_addr_b = w_idx_m1[AW-1:0];
            end
            OP_EXT_SWAP: begin
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                w_wdata = r_rda;
            end
            OP_EMIT_RD: begin
                w_addr_a = r_idx[AW-1:0];
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rda <= r_mem[w_addr_a];
        r_rdb <= r_mem[w_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_op)
                OP_STORE: begin
                    if (w_room) begin
                        r_count <= r_count + CW'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                OP_EMIT_DONE: begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
            if (i_op == OP_EMIT_LD) begin
                r_out_valid <= 1'b1;
            end else if (i_out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sift and loop registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_BUILD_INIT: begin
                r_idx  <= r_count >> 1;
                r_size <= r_count;
            end
            OP_ROOT_RD: begin
                r_idx  <= w_idx_m1;
                r_hole <= w_idx_m1[AW-1:0];
            end
            OP_VAL_ROOT: begin
                r_val <= r_rda;
            end
            OP_SIFT_STEP: begin
                if (w_sel_r) begin
                    r_hole <= w_right[AW-1:0];
                end else if (w_sel_l) begin
                    r_hole <= w_left[AW-1:0];
                end
            end
            OP_EXT_INIT: begin
                r_idx <= r_count;
            end
            OP_EXT_RD: begin
                r_idx  <= w_idx_m1;
                r_size <= w_idx_m1;
            end
            OP_EXT_SWAP: begin
                r_val  <= r_rdb;
                r_hole <= '0;
            end
            OP_EMIT_INIT: begin
                r_idx <= '0;
            end
            OP_EMIT_LD: begin
                r_out_key   <= r_rda;
                r_out_final <= (r_idx + CW'(1)) == r_count;
                r_out_drop  <= r_ovf;
                r_idx       <= r_idx + CW'(1);
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_stat.idx_zero  = (r_idx == '0);
    assign o_stat.idx_lt2   = (r_idx < CW'(2));
    assign o_stat.sift_stop = !w_move;
    assign o_stat.out_final = r_out_final;

    assign o_out_valid = r_out_valid;
    assign o_out_key   = r_out_key;
    assign o_out_final = r_out_final;
    assign o_out_drop  = r_out_drop;

endmodule

// ===== hdl/heap_sort_engine.sv =====
`timescale 1ns / 1ps
// load: one key per cycle, input ready only while collecting a set
// sort: about n/2 + n-1 sift-downs, each a setup then a read and compare per level,
//   bounded by the single write port and the registered two-port key store
// emit: each key is loaded into the result register and held there until taken
// reset: synchronous active low clears the sequencer, set count and drop flag;
//   the key store is not cleared and needs no sweep
// ----------------------------------------------------------------------------
// heap_sort_engine
// collects a set of signed keys, heapsorts them in place, emits them ascending
// ----------------------------------------------------------------------------
module heap_sort_engine import hse_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hse_in_if.sink    i_in,
    hse_out_if.source o_out
);

    t_op   w_op;
    t_stat w_stat;
    logic  w_in_ready;
    logic  w_out_valid;
    logic  w_out_fire;

    assign w_out_fire = w_out_valid && o_out.ready;
    assign i_in.ready = w_in_ready;
    assign o_out.valid = w_out_valid;

    hse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last),
        .i_out_fire (w_out_fire),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_op       (w_op)
    );

    hse_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_key       (i_in.key),
        .i_out_fire  (w_out_fire),
        .o_stat      (w_stat),
        .o_out_valid (w_out_valid),
        .o_out_key   (o_out.sorted_key),
        .o_out_final (o_out.final_res),
        .o_out_drop  (o_out.dropped)
    );

endmodule
